FILE: sv/csc_pkg.sv
// shared types, constants and helpers for the pixel color space converter
`default_nettype none

package csc_pkg;

  typedef enum logic [1:0] {
    MODE_RGB2HSV = 2'd0,
    MODE_HSV2RGB = 2'd1,
    MODE_RGB2RGI = 2'd2,
    MODE_RGI2RGB = 2'd3
  } mode_t;

  // pipeline layout: two prep stages, divider stages, two post stages
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned NUM_STAGES = 2 + DIV_STAGES + 2;

  localparam logic [7:0]  NEUTRAL_CHROMA = 8'd85;
  localparam logic [9:0]  DARK_SUM       = 10'd10;
  localparam logic [9:0]  PULL_SUM       = 10'd45;

  // reciprocals for division by constants
  localparam logic [9:0]  RECIP_3  = 10'd683;    // x/3  = x*683 >> 11
  localparam logic [15:0] RECIP_85 = 16'd49345;  // x/85 = x*49345 >> 22
  localparam logic [11:0] RECIP_9  = 12'd3641;   // x/9  = x*3641 >> 15

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic        rmax;
    logic        gmax;
    logic [9:0]  s;
    logic [2:0]  sec;
    logic [7:0]  f;
    logic [7:0]  b8;
  } p1_t;

  typedef struct packed {
    mode_t       mode;
    logic        zero;
    logic        low_s;
    logic [5:0]  s45;
    logic [7:0]  x0;
    logic [7:0]  x1;
    logic [2:0]  sec;
    logic [15:0] prod0;
    logic [15:0] prod1;
    logic [15:0] prod2;
  } side_t;

  typedef struct packed {
    logic [18:0] rem0;
    logic [18:0] rem1;
    logic [17:0] dsh;
    logic [7:0]  q0;
    logic [7:0]  q1;
  } div_t;

  typedef struct packed {
    logic               pull;
    logic signed [14:0] v0;
    logic signed [14:0] v1;
    logic signed [14:0] v2;
  } q1_t;

  // floor(x/255), exact for any x below 65280, where the quotient fits in 8 bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return acc[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: sv/pixel_color_space_converter.sv
// top level: mode register, stage valid bits and stall chain, datapath stages
//
//  port group    direction  handshake          payload
//  in_*          in         in_valid/in_stall  in_chan_a, in_chan_b, in_chan_c
//  out_*         out        out_valid/out_stall out_chan_a/b/c, out_range_clipped
//  cfg_*         in         cfg_valid/cfg_ready cfg_conversion_mode
//
// one item per cycle sustained while out_stall is low; eight register stages: two
// prep stages, four divider stages at two quotient bits each, two post stages.
// items pass them in order. a stage holds while the stage after it is full
// and held, so out_stall backs up into in_stall only once every stage is occupied.
// synchronous reset clears the valid bits and sets the mode to rgb to hsv.
`default_nettype none

module pixel_color_space_converter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_chan_a,
  input  wire logic [7:0] in_chan_b,
  input  wire logic [7:0] in_chan_c,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_chan_a,
  output logic [7:0]      out_chan_b,
  output logic [7:0]      out_chan_c,
  output logic            out_range_clipped,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_conversion_mode
);
  import csc_pkg::*;

  mode_t mode_r;
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGB2HSV;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= mode_t'(cfg_conversion_mode);
    end
  end

  // a stage loads when empty or when the next stage loads too
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    if (en[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  div_t  dv [DIV_STAGES+1];
  side_t sd [DIV_STAGES+1];

  csc_prep u_prep (
    .clk    (clk),
    .en_p1  (en[0]),
    .en_p2  (en[1]),
    .mode   (mode_r),
    .a      (in_chan_a),
    .b      (in_chan_b),
    .c      (in_chan_c),
    .div_r  (dv[0]),
    .side_r (sd[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    csc_div_stage u_div (
      .clk    (clk),
      .en     (en[2+g]),
      .div_i  (dv[g]),
      .side_i (sd[g]),
      .div_r  (dv[g+1]),
      .side_r (sd[g+1])
    );
  end

  csc_post u_post (
    .clk      (clk),
    .en_q1    (en[NUM_STAGES-2]),
    .en_q2    (en[NUM_STAGES-1]),
    .div_i    (dv[DIV_STAGES]),
    .side_i   (sd[DIV_STAGES]),
    .chan_a_r (out_chan_a),
    .chan_b_r (out_chan_b),
    .chan_c_r (out_chan_c),
    .clip_r   (out_range_clipped)
  );

  // an empty output stage never backs up the input
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  // a full, held pipeline must stall the input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && out_stall) |-> in_stall)
    else $error("item accepted into full held pipeline");

  // a held divider stage keeps its item
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && !en[2]) |=> vld_r[2])
    else $error("held divider stage lost its item");

endmodule

`default_nettype wire

FILE: sv/csc_prep.sv
// two front stages: channel extremes, sums, sectors, then divider operands and products
`default_nettype none

module csc_prep (
  input  wire logic           clk,
  input  wire logic           en_p1,
  input  wire logic           en_p2,
  input  wire csc_pkg::mode_t mode,
  input  wire logic [7:0]     a,
  input  wire logic [7:0]     b,
  input  wire logic [7:0]     c,
  output csc_pkg::div_t       div_r,
  output csc_pkg::side_t      side_r
);
  import csc_pkg::*;

  p1_t   p1_nxt, p1_r;
  div_t  div_nxt;
  side_t side_nxt;

  logic [10:0] hh;
  logic [10:0] base;

  always_comb begin
    p1_nxt      = '0;
    p1_nxt.mode = mode;
    p1_nxt.a    = a;
    p1_nxt.b    = b;
    p1_nxt.c    = c;
    p1_nxt.mx   = (a > b) ? a : b;
    if (c > p1_nxt.mx) p1_nxt.mx = c;
    p1_nxt.mn   = (a < b) ? a : b;
    if (c < p1_nxt.mn) p1_nxt.mn = c;
    p1_nxt.rmax = (a == p1_nxt.mx);
    p1_nxt.gmax = (b == p1_nxt.mx);
    p1_nxt.s    = 10'(a) + 10'(b) + 10'(c);
    p1_nxt.b8   = 8'(8'd255 - a - b);
    // hue 255 wraps to sector zero
    hh = (a == 8'd255) ? 11'd0 : ({3'b0, a} << 2) + ({3'b0, a} << 1);
    priority if (hh >= 11'd1275) begin
      p1_nxt.sec = 3'd5; base = 11'd1275;
    end else if (hh >= 11'd1020) begin
      p1_nxt.sec = 3'd4; base = 11'd1020;
    end else if (hh >= 11'd765) begin
      p1_nxt.sec = 3'd3; base = 11'd765;
    end else if (hh >= 11'd510) begin
      p1_nxt.sec = 3'd2; base = 11'd510;
    end else if (hh >= 11'd255) begin
      p1_nxt.sec = 3'd1; base = 11'd255;
    end else begin
      p1_nxt.sec = 3'd0; base = 11'd0;
    end
    p1_nxt.f = 8'(hh - base);
  end

  always_ff @(posedge clk) begin
    if (en_p1) begin
      p1_r <= p1_nxt;
    end
  end

  logic [7:0]         d;
  logic [10:0]        d6;
  logic signed [12:0] n;
  logic [18:0]        n255;
  logic [19:0]        inten_m;

  always_comb begin
    d    = p1_r.mx - p1_r.mn;
    d6   = ({3'b0, d} << 2) + ({3'b0, d} << 1);
    priority if (p1_r.rmax) begin
      n = 13'(signed'({1'b0, p1_r.b})) - 13'(signed'({1'b0, p1_r.c}));
      if (n < 0) n = n + 13'(signed'({1'b0, d6}));
    end else if (p1_r.gmax) begin
      n = 13'(signed'({1'b0, d, 1'b0})) + 13'(signed'({1'b0, p1_r.c}))
          - 13'(signed'({1'b0, p1_r.a}));
    end else begin
      n = 13'(signed'({1'b0, d, 2'b0})) + 13'(signed'({1'b0, p1_r.a}))
          - 13'(signed'({1'b0, p1_r.b}));
    end
    n255    = (19'(n[11:0]) << 8) - 19'(n[11:0]);
    // (2s+3)/6 equals (s+1)/3
    inten_m = 20'(p1_r.s + 10'd1) * 20'(RECIP_3);

    div_nxt  = '0;
    div_nxt.dsh = 18'd1 << 7;
    side_nxt = '0;
    side_nxt.mode  = p1_r.mode;
    side_nxt.sec   = p1_r.sec;
    side_nxt.low_s = (p1_r.s < PULL_SUM);
    side_nxt.s45   = 6'(PULL_SUM - p1_r.s);
    unique case (p1_r.mode)
      MODE_RGB2HSV: begin
        div_nxt.rem0  = n255;
        div_nxt.dsh   = 18'(d6) << 7;
        side_nxt.zero = (d == 8'd0);
        side_nxt.x0   = d;
        side_nxt.x1   = p1_r.mx;
      end
      MODE_HSV2RGB: begin
        side_nxt.zero  = (p1_r.b == 8'd0);
        side_nxt.x0    = p1_r.c;
        side_nxt.x1    = p1_r.b;
        side_nxt.prod0 = 16'(p1_r.b) * 16'(p1_r.f);
        side_nxt.prod1 = 16'(p1_r.b) * 16'(8'd255 - p1_r.f);
      end
      MODE_RGB2RGI: begin
        div_nxt.rem0  = (19'(p1_r.a) << 8) - 19'(p1_r.a);
        div_nxt.rem1  = (19'(p1_r.b) << 8) - 19'(p1_r.b);
        div_nxt.dsh   = 18'(p1_r.s) << 7;
        side_nxt.zero = (p1_r.s < DARK_SUM);
        side_nxt.x0   = inten_m[18:11];
      end
      MODE_RGI2RGB: begin
        side_nxt.prod0 = 16'(p1_r.a) * 16'(p1_r.c);
        side_nxt.prod1 = 16'(p1_r.b) * 16'(p1_r.c);
        side_nxt.prod2 = 16'(p1_r.b8) * 16'(p1_r.c);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_p2) begin
      div_r  <= div_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/csc_div_stage.sv
// one stage of the two-lane restoring divider, a fixed number of quotient bits per stage
`default_nettype none

module csc_div_stage (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire csc_pkg::div_t   div_i,
  input  wire csc_pkg::side_t  side_i,
  output csc_pkg::div_t        div_r,
  output csc_pkg::side_t       side_r
);
  import csc_pkg::*;

  div_t div_nxt;

  always_comb begin
    div_nxt = div_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (div_nxt.rem0 >= {1'b0, div_nxt.dsh}) begin
        div_nxt.rem0 = div_nxt.rem0 - {1'b0, div_nxt.dsh};
        div_nxt.q0   = {div_nxt.q0[6:0], 1'b1};
      end else begin
        div_nxt.q0   = {div_nxt.q0[6:0], 1'b0};
      end
      if (div_nxt.rem1 >= {1'b0, div_nxt.dsh}) begin
        div_nxt.rem1 = div_nxt.rem1 - {1'b0, div_nxt.dsh};
        div_nxt.q1   = {div_nxt.q1[6:0], 1'b1};
      end else begin
        div_nxt.q1   = {div_nxt.q1[6:0], 1'b0};
      end
      div_nxt.dsh = div_nxt.dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= side_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/csc_post.sv
// two back stages: per-mode channel values, then chroma pull, clipping and output register
`default_nettype none

module csc_post (
  input  wire logic           clk,
  input  wire logic           en_q1,
  input  wire logic           en_q2,
  input  wire csc_pkg::div_t  div_i,
  input  wire csc_pkg::side_t side_i,
  output logic [7:0]          chan_a_r,
  output logic [7:0]          chan_b_r,
  output logic [7:0]          chan_c_r,
  output logic                clip_r
);
  import csc_pkg::*;

  q1_t q1_nxt, q1_r;

  // truncated v - d*x/255, from floor(d*x/255) and its remainder
  function automatic logic signed [10:0] sub_frac(input logic [7:0] v,
                                                  input logic [15:0] prod);
    logic [7:0]  qd;
    logic [15:0] back;
    logic [15:0] v255;
    logic        adj;
    qd   = div255(prod);
    back = (16'(qd) << 8) - 16'(qd);
    v255 = (16'(v) << 8) - 16'(v);
    adj  = (back != prod) && (prod <= v255);
    return 11'(signed'({1'b0, v})) - 11'(signed'({1'b0, qd})) - 11'(signed'({1'b0, adj}));
  endfunction

  // 36*x + (85-x)*(45-s), divided by 36 in the next stage
  function automatic logic signed [14:0] pull_num(input logic [7:0] x,
                                                  input logic [5:0] s45);
    logic [13:0]        x36;
    logic signed [15:0] dd;
    logic signed [15:0] y;
    x36 = (14'(x) << 5) + (14'(x) << 2);
    dd  = 16'(signed'({1'b0, NEUTRAL_CHROMA})) - 16'(signed'({1'b0, x}));
    y   = 16'(signed'({1'b0, x36})) + dd * 16'(signed'({1'b0, s45}));
    return y[14:0];
  endfunction

  function automatic logic signed [14:0] div85(input logic [15:0] prod);
    logic [31:0] m;
    m = 32'(prod) * 32'(RECIP_85);
    return 15'(signed'({1'b0, m[31:22]}));
  endfunction

  logic signed [10:0] pv, qv, tv;
  logic signed [14:0] vv, pe, qe, te;
  logic [7:0]         cr, cg;

  always_comb begin
    q1_nxt = '0;
    pv = 11'(signed'({1'b0, side_i.x0})) - 11'(signed'({1'b0, side_i.x1}));
    qv = sub_frac(side_i.x0, side_i.prod0);
    tv = sub_frac(side_i.x0, side_i.prod1);
    vv = 15'(signed'({1'b0, side_i.x0}));
    pe = 15'(pv);
    qe = 15'(qv);
    te = 15'(tv);
    cr = side_i.zero ? NEUTRAL_CHROMA : div_i.q0;
    cg = side_i.zero ? NEUTRAL_CHROMA : div_i.q1;
    unique case (side_i.mode)
      MODE_RGB2HSV: begin
        q1_nxt.v0 = side_i.zero ? '0 : 15'(signed'({1'b0, div_i.q0}));
        q1_nxt.v1 = 15'(signed'({1'b0, side_i.x0}));
        q1_nxt.v2 = 15'(signed'({1'b0, side_i.x1}));
      end
      MODE_HSV2RGB: begin
        if (side_i.zero) begin
          q1_nxt.v0 = vv; q1_nxt.v1 = vv; q1_nxt.v2 = vv;
        end else begin
          unique case (side_i.sec)
            3'd0: begin q1_nxt.v0 = vv; q1_nxt.v1 = te; q1_nxt.v2 = pe; end
            3'd1: begin q1_nxt.v0 = qe; q1_nxt.v1 = vv; q1_nxt.v2 = pe; end
            3'd2: begin q1_nxt.v0 = pe; q1_nxt.v1 = vv; q1_nxt.v2 = te; end
            3'd3: begin q1_nxt.v0 = pe; q1_nxt.v1 = qe; q1_nxt.v2 = vv; end
            3'd4: begin q1_nxt.v0 = te; q1_nxt.v1 = pe; q1_nxt.v2 = vv; end
            default: begin q1_nxt.v0 = vv; q1_nxt.v1 = pe; q1_nxt.v2 = qe; end
          endcase
        end
      end
      MODE_RGB2RGI: begin
        // dim pixels get their chroma pulled toward neutral
        q1_nxt.pull = !side_i.zero && side_i.low_s;
        q1_nxt.v0   = q1_nxt.pull ? pull_num(cr, side_i.s45) : 15'(signed'({1'b0, cr}));
        q1_nxt.v1   = q1_nxt.pull ? pull_num(cg, side_i.s45) : 15'(signed'({1'b0, cg}));
        q1_nxt.v2   = 15'(signed'({1'b0, side_i.x0}));
      end
      MODE_RGI2RGB: begin
        q1_nxt.v0 = div85(side_i.prod0);
        q1_nxt.v1 = div85(side_i.prod1);
        q1_nxt.v2 = div85(side_i.prod2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_q1) begin
      q1_r <= q1_nxt;
    end
  end

  // returns {clipped, value}
  function automatic logic [8:0] finish(input logic signed [14:0] v, input logic pull);
    logic [23:0] m;
    m = 24'(v[13:2]) * 24'(RECIP_9);
    if (pull) begin
      return {1'b0, m[22:15]};
    end else if (v < 0) begin
      return {1'b1, 8'd0};
    end else if (v > 15'sd255) begin
      return {1'b1, 8'hFF};
    end else begin
      return {1'b0, v[7:0]};
    end
  endfunction

  logic [8:0] f0, f1, f2;

  always_comb begin
    f0 = finish(q1_r.v0, q1_r.pull);
    f1 = finish(q1_r.v1, q1_r.pull);
    f2 = finish(q1_r.v2, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (en_q2) begin
      chan_a_r <= f0[7:0];
      chan_b_r <= f1[7:0];
      chan_c_r <= f2[7:0];
      clip_r   <= f0[8] | f1[8] | f2[8];
    end
  end

endmodule

`default_nettype wire

FILE: dv/pixel_color_space_converter_tb.sv
// testbench for pixel_color_space_converter: directed table, random pixels, scoreboard
`timescale 1ns / 1ps

module pixel_color_space_converter_tb;
  import csc_pkg::*;

  typedef struct {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       clip;
  } pixel_t;

  typedef struct {
    mode_t      mode;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    bit         typed;
    pixel_t     want;
  } vec_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_chan_a;
  logic [7:0] in_chan_b;
  logic [7:0] in_chan_c;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_chan_a;
  logic [7:0] out_chan_b;
  logic [7:0] out_chan_c;
  logic       out_range_clipped;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_conversion_mode;

  pixel_t pixel_q[$];
  mode_t  cur_mode;
  int     mismatches;
  int     stuck_cycles;
  bit     calm;
  bit     hold_req;

  pixel_color_space_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_chan_a(in_chan_a), .in_chan_b(in_chan_b), .in_chan_c(in_chan_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_chan_a(out_chan_a), .out_chan_b(out_chan_b), .out_chan_c(out_chan_c),
    .out_range_clipped(out_range_clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_conversion_mode(cfg_conversion_mode)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // {clipped, value}
  function automatic logic [8:0] clamp8(int x);
    if (x < 0) return 9'h100;
    if (x > 255) return 9'h1ff;
    return {1'b0, x[7:0]};
  endfunction

  function automatic pixel_t convert_pixel(mode_t m, logic [7:0] ia, logic [7:0] ib,
                                           logic [7:0] ic);
    pixel_t o;
    int a, b, c, mx, mn, d, n, hh, sec, f, p, q, t, x, y, z, s, cr, cg, bb;
    logic [8:0] ca, cb, cc;
    a = ia; b = ib; c = ic;
    o.clip = 1'b0;
    case (m)
      MODE_RGB2HSV: begin
        mx = a; mn = a;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        if (c > mx) mx = c;
        if (c < mn) mn = c;
        d = mx - mn;
        n = 0;
        if (d != 0) begin
          if (a == mx) begin
            n = b - c;
            if (n < 0) n += 6 * d;
          end else if (b == mx) n = 2 * d + c - a;
          else n = 4 * d + a - b;
          n = (255 * n) / (6 * d);
        end
        o.a = n[7:0]; o.b = d[7:0]; o.c = mx[7:0];
      end
      MODE_HSV2RGB: begin
        if (b == 0) begin
          o.a = ic; o.b = ic; o.c = ic;
        end else begin
          hh = (a == 255) ? 0 : 6 * a;
          sec = hh / 255;
          f = hh % 255;
          p = c - b;
          q = (255 * c - b * f) / 255;
          t = (255 * c - b * (255 - f)) / 255;
          case (sec)
            0: begin x = c; y = t; z = p; end
            1: begin x = q; y = c; z = p; end
            2: begin x = p; y = c; z = t; end
            3: begin x = p; y = q; z = c; end
            4: begin x = t; y = p; z = c; end
            default: begin x = c; y = p; z = q; end
          endcase
          ca = clamp8(x); cb = clamp8(y); cc = clamp8(z);
          o.a = ca[7:0]; o.b = cb[7:0]; o.c = cc[7:0];
          o.clip = ca[8] | cb[8] | cc[8];
        end
      end
      MODE_RGB2RGI: begin
        s = a + b + c;
        cr = 85; cg = 85;
        if (s >= 10) begin
          cr = (255 * a) / s;
          cg = (255 * b) / s;
          // dark pixels are pulled toward neutral chroma
          if (s < 45) begin
            cr = (36 * cr + (85 - cr) * (45 - s)) / 36;
            cg = (36 * cg + (85 - cg) * (45 - s)) / 36;
          end
        end
        s = (2 * s + 3) / 6;
        o.a = cr[7:0]; o.b = cg[7:0]; o.c = s[7:0];
      end
      default: begin
        bb = (255 - a - b) & 255;
        ca = clamp8((3 * c * a) / 255);
        cb = clamp8((3 * c * b) / 255);
        cc = clamp8((3 * c * bb) / 255);
        o.a = ca[7:0]; o.b = cb[7:0]; o.c = cc[7:0];
        o.clip = ca[8] | cb[8] | cc[8];
      end
    endcase
    return o;
  endfunction

  function automatic vec_t row(mode_t m, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                               bit typed = 0, logic [7:0] wa = 0, logic [7:0] wb = 0,
                               logic [7:0] wc = 0, logic wclip = 0);
    vec_t v;
    v.mode = m; v.a = a; v.b = b; v.c = c; v.typed = typed;
    v.want.a = wa; v.want.b = wb; v.want.c = wc; v.want.clip = wclip;
    return v;
  endfunction

  function automatic logic [7:0] pick_chan();
    if ($urandom_range(3) == 0) return 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit typed,
                            pixel_t want);
    in_valid  <= 1'b1;
    in_chan_a <= a;
    in_chan_b <= b;
    in_chan_c <= c;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(typed ? want : convert_pixel(cur_mode, a, b, c));
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    cfg_valid           <= 1'b1;
    cfg_conversion_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  // receiver side: random stalls, calm stretches, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %0d %0d %0d clip %0b",
                                       out_chan_a, out_chan_b, out_chan_c, out_range_clipped);
      end else begin
        pixel_t w;
        w = pixel_q.pop_front();
        if (w.a !== out_chan_a || w.b !== out_chan_b || w.c !== out_chan_c ||
            w.clip !== out_range_clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
                     w.a, w.b, w.c, w.clip,
                     out_chan_a, out_chan_b, out_chan_c, out_range_clipped);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("pixel_color_space_converter verification failed");
      $finish;
    end
  end

  initial begin
    vec_t   dir_rows[$];
    mode_t  m;
    pixel_t none;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_chan_a           <= '0;
    in_chan_b           <= '0;
    in_chan_c           <= '0;
    cfg_valid           <= 1'b0;
    cfg_conversion_mode <= MODE_RGB2HSV;
    calm       = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    stuck_cycles = 0;
    cur_mode   = MODE_RGB2HSV;
    none       = '{default: 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rgb to hsv runs from reset without a register write
    dir_rows.push_back(row(MODE_RGB2HSV, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(MODE_RGB2HSV, 255, 0, 0, 1, 0, 255, 255, 0));
    dir_rows.push_back(row(MODE_RGB2HSV, 255, 255, 255, 1, 0, 0, 255, 0));
    dir_rows.push_back(row(MODE_RGB2HSV, 10, 200, 30));
    dir_rows.push_back(row(MODE_RGB2HSV, 40, 3, 250));
    dir_rows.push_back(row(MODE_RGB2HSV, 200, 7, 90));
    dir_rows.push_back(row(MODE_HSV2RGB, 17, 0, 200, 1, 200, 200, 200, 0));
    dir_rows.push_back(row(MODE_HSV2RGB, 0, 255, 0, 1, 0, 0, 0, 1));
    dir_rows.push_back(row(MODE_HSV2RGB, 255, 100, 200));
    dir_rows.push_back(row(MODE_HSV2RGB, 90, 250, 30));
    dir_rows.push_back(row(MODE_HSV2RGB, 170, 60, 255));
    dir_rows.push_back(row(MODE_HSV2RGB, 230, 255, 255));
    dir_rows.push_back(row(MODE_RGB2RGI, 0, 0, 0, 1, 85, 85, 0, 0));
    dir_rows.push_back(row(MODE_RGB2RGI, 255, 255, 255, 1, 85, 85, 255, 0));
    dir_rows.push_back(row(MODE_RGB2RGI, 3, 3, 3));
    dir_rows.push_back(row(MODE_RGB2RGI, 20, 2, 3));
    dir_rows.push_back(row(MODE_RGB2RGI, 255, 0, 1));
    dir_rows.push_back(row(MODE_RGI2RGB, 255, 255, 255, 1, 255, 255, 3, 1));
    dir_rows.push_back(row(MODE_RGI2RGB, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(MODE_RGI2RGB, 200, 100, 90));
    dir_rows.push_back(row(MODE_RGI2RGB, 85, 85, 100));
    dir_rows.push_back(row(MODE_RGI2RGB, 0, 255, 170));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) begin
        drain();
        write_mode(dir_rows[i].mode);
      end
      send_pixel(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].typed,
                 dir_rows[i].want);
    end

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      m = mode_t'((phase * 3 + 1) % 4);
      write_mode(m);
      calm = (phase == 2);
      if (phase == 4) hold_req = 1'b1;
      for (int k = 0; k < 92; k++) begin
        // sender pause until the pipe is empty, mid-phase
        if (phase == 5 && k == 46) drain();
        send_pixel(pick_chan(), pick_chan(), pick_chan(), 0, none);
      end
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0)
      $display("pixel_color_space_converter verification clean");
    else
      $display("pixel_color_space_converter verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/csc_pkg.sv
sv/csc_prep.sv
sv/csc_div_stage.sv
sv/csc_post.sv
sv/pixel_color_space_converter.sv
dv/pixel_color_space_converter_tb.sv
